[rtl/link_loss_supervisor_defines.svh]
// Assertion macros shared by the link-loss supervisor checker.
// No dependencies; include with the bare file name.
`ifndef LINK_LOSS_SUPERVISOR_DEFINES_SVH
`define LINK_LOSS_SUPERVISOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LLS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lls_pkg.sv]
// Shared types and constants for the link-loss supervisor.
// No dependencies; used by every module of the block.
package lls_pkg;

    localparam int CfgIndexWidth = 4;
    localparam int CfgDataWidth  = 32;

    localparam logic [CfgIndexWidth-1:0] CfgWarningRssi   = 4'd0;
    localparam logic [CfgIndexWidth-1:0] CfgLeashRssi     = 4'd1;
    localparam logic [CfgIndexWidth-1:0] CfgLeashSamples  = 4'd2;
    localparam logic [CfgIndexWidth-1:0] CfgLeashTimeout  = 4'd3;
    localparam logic [CfgIndexWidth-1:0] CfgLossTimeout   = 4'd4;
    localparam logic [CfgIndexWidth-1:0] CfgLeashEnable   = 4'd5;
    localparam logic [CfgIndexWidth-1:0] CfgPauseOnLeash  = 4'd6;
    localparam logic [CfgIndexWidth-1:0] CfgRecoveryEnable = 4'd7;

    localparam logic signed [7:0] WarningRssiReset   = -8'sd70;
    localparam logic signed [7:0] LeashRssiReset     = -8'sd70;
    localparam logic [7:0]        LeashSamplesReset  = 8'd5;
    localparam logic [31:0]       LeashTimeoutReset  = 32'd60000;
    localparam logic [31:0]       LossTimeoutReset   = 32'd30000;

    localparam logic [31:0] SuccessHoldMs = 32'd3000;
    localparam logic [7:0]  LeashCountMax = 8'd255;

    localparam logic [1:0] ReasonNone        = 2'd0;
    localparam logic [1:0] ReasonRecoveryOff = 2'd1;
    localparam logic [1:0] ReasonRecoveryFail = 2'd2;
    localparam logic [1:0] ReasonReacquired  = 2'd3;

    localparam logic [2:0] ModeMonitoring  = 3'd0;
    localparam logic [2:0] ModeDegraded    = 3'd1;
    localparam logic [2:0] ModeLeash       = 3'd2;
    localparam logic [2:0] ModeLostWaiting = 3'd3;
    localparam logic [2:0] ModeRecovering  = 3'd4;
    localparam logic [2:0] ModeSucceeded   = 3'd5;
    localparam logic [2:0] ModeFailed      = 3'd6;

    typedef struct packed {
        logic signed [7:0] warning_rssi;
        logic signed [7:0] leash_rssi;
        logic [7:0]        leash_samples_needed;
        logic [31:0]       leash_timeout_ms;
        logic [31:0]       loss_timeout_ms;
        logic              leash_enable;
        logic              pause_on_leash;
        logic              recovery_enable;
    } cfg_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       recovery_start;
        logic       cancel_goals;
        logic [1:0] reason;
        logic       mode_changed;
    } result_t;

endpackage

[rtl/link_loss_supervisor.sv]
// Link-loss supervisor. The accepting edge loads the input register; the result
// register loads from it once the result register is empty or its result is taken.
// Throughput: one tick per cycle unless m_ready stalls the output; the input register
// refills in the cycle the result register is loaded or emptied.
// Reset: synchronous, active low; clears the mode, counters, timestamps and
// reason, and loads the configuration registers with their defaults.
module link_loss_supervisor (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_link_up,
    input  logic signed [7:0]                 s_rssi,
    input  logic                              s_trend_falling,
    input  logic [31:0]                       s_time_ms,
    input  logic                              s_nav_nothing_to_do,
    input  logic                              s_nav_all_done,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_mode,
    output logic                              m_recovery_start,
    output logic                              m_cancel_goals,
    output logic [1:0]                        m_reason,
    output logic                              m_mode_changed,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lls_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [lls_pkg::CfgDataWidth-1:0]  cfg_data
);

    lls_pkg::cfg_t    cfg;
    lls_pkg::result_t result;
    lls_pkg::result_t out_reg;

    logic              in_valid_reg;
    logic              link_up_reg;
    logic signed [7:0] rssi_reg;
    logic              falling_reg;
    logic [31:0]       time_reg;
    logic              nothing_reg;
    logic              all_done_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              step;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_ready;
    assign step      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;

    lls_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            link_up_reg  <= s_link_up;
            rssi_reg     <= s_rssi;
            falling_reg  <= s_trend_falling;
            time_reg     <= s_time_ms;
            nothing_reg  <= s_nav_nothing_to_do;
            all_done_reg <= s_nav_all_done;
        end
    end

    lls_fsm u_fsm (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .step              (step),
        .link_up           (link_up_reg),
        .rssi              (rssi_reg),
        .trend_falling     (falling_reg),
        .time_ms           (time_reg),
        .nav_nothing_to_do (nothing_reg),
        .nav_all_done      (all_done_reg),
        .cfg               (cfg),
        .result            (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_mode           = out_reg.mode;
    assign m_recovery_start = out_reg.recovery_start;
    assign m_cancel_goals   = out_reg.cancel_goals;
    assign m_reason         = out_reg.reason;
    assign m_mode_changed   = out_reg.mode_changed;

endmodule

[rtl/lls_cfg_regs.sv]
// Configuration register file of the link-loss supervisor.
// Depends on lls_pkg for register indexes, reset values and cfg_t.
module lls_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [lls_pkg::CfgIndexWidth-1:0] wr_index,
    input  logic [lls_pkg::CfgDataWidth-1:0]  wr_data,
    output lls_pkg::cfg_t                     cfg
);

    lls_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.warning_rssi         <= lls_pkg::WarningRssiReset;
            cfg_reg.leash_rssi           <= lls_pkg::LeashRssiReset;
            cfg_reg.leash_samples_needed <= lls_pkg::LeashSamplesReset;
            cfg_reg.leash_timeout_ms     <= lls_pkg::LeashTimeoutReset;
            cfg_reg.loss_timeout_ms      <= lls_pkg::LossTimeoutReset;
            cfg_reg.leash_enable         <= 1'b1;
            cfg_reg.pause_on_leash       <= 1'b0;
            cfg_reg.recovery_enable      <= 1'b1;
        end else if (wr_en) begin
            unique case (wr_index)
                lls_pkg::CfgWarningRssi:    cfg_reg.warning_rssi <= $signed(wr_data[7:0]);
                lls_pkg::CfgLeashRssi:      cfg_reg.leash_rssi <= $signed(wr_data[7:0]);
                lls_pkg::CfgLeashSamples:   cfg_reg.leash_samples_needed <= wr_data[7:0];
                lls_pkg::CfgLeashTimeout:   cfg_reg.leash_timeout_ms <= wr_data[31:0];
                lls_pkg::CfgLossTimeout:    cfg_reg.loss_timeout_ms <= wr_data[31:0];
                lls_pkg::CfgLeashEnable:    cfg_reg.leash_enable <= wr_data[0];
                lls_pkg::CfgPauseOnLeash:   cfg_reg.pause_on_leash <= wr_data[0];
                lls_pkg::CfgRecoveryEnable: cfg_reg.recovery_enable <= wr_data[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/lls_fsm.sv]
// Supervisor state machine: holds the mode, leash counter and timestamps,
// and computes one result per tick. Depends on lls_pkg.
module lls_fsm (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic                 link_up,
    input  logic signed [7:0]    rssi,
    input  logic                 trend_falling,
    input  logic [31:0]          time_ms,
    input  logic                 nav_nothing_to_do,
    input  logic                 nav_all_done,
    input  lls_pkg::cfg_t        cfg,
    output lls_pkg::result_t     result
);

    typedef enum logic [2:0] {
        MODE_MONITOR    = lls_pkg::ModeMonitoring,
        MODE_DEGRADED   = lls_pkg::ModeDegraded,
        MODE_LEASH      = lls_pkg::ModeLeash,
        MODE_LOST_WAIT  = lls_pkg::ModeLostWaiting,
        MODE_RECOVERING = lls_pkg::ModeRecovering,
        MODE_SUCCEEDED  = lls_pkg::ModeSucceeded,
        MODE_FAILED     = lls_pkg::ModeFailed
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [7:0]  leash_count_reg, leash_count_next;
    logic [31:0] leash_start_reg, leash_start_next;
    logic        leash_valid_reg, leash_valid_next;
    logic [31:0] lost_start_reg, lost_start_next;
    logic [31:0] success_start_reg, success_start_next;
    logic        success_valid_reg, success_valid_next;
    logic [1:0]  reason_reg, reason_next;

    logic        recovery_start;
    logic        cancel_goals;
    logic        rssi_low;
    logic        leash_sample;
    logic [7:0]  count_inc;
    logic        leash_enter;
    logic        leash_expired;
    logic        loss_expired;
    logic        hold_expired;

    assign rssi_low      = (rssi != 8'sd0) && (rssi < cfg.warning_rssi);
    assign leash_sample  = cfg.leash_enable && trend_falling && (rssi < cfg.leash_rssi);
    assign count_inc     = (leash_count_reg == lls_pkg::LeashCountMax) ?
                           leash_count_reg : leash_count_reg + 8'd1;
    assign leash_enter   = count_inc >= cfg.leash_samples_needed;
    assign leash_expired = (time_ms - leash_start_reg) >= cfg.leash_timeout_ms;
    assign loss_expired  = (time_ms - lost_start_reg) >= cfg.loss_timeout_ms;
    assign hold_expired  = (time_ms - success_start_reg) >= lls_pkg::SuccessHoldMs;

    always_comb begin
        mode_next          = mode_reg;
        leash_count_next   = leash_count_reg;
        leash_start_next   = leash_start_reg;
        leash_valid_next   = leash_valid_reg;
        lost_start_next    = lost_start_reg;
        success_start_next = success_start_reg;
        success_valid_next = success_valid_reg;
        reason_next        = reason_reg;
        recovery_start     = 1'b0;
        cancel_goals       = 1'b0;

        unique case (mode_reg)
            MODE_MONITOR, MODE_DEGRADED: begin
                if (!link_up) begin
                    mode_next        = MODE_LOST_WAIT;
                    lost_start_next  = time_ms;
                    leash_valid_next = 1'b0;
                end else if (!rssi_low) begin
                    mode_next        = MODE_MONITOR;
                    leash_count_next = '0;
                end else if (leash_sample) begin
                    leash_count_next = count_inc;
                    if (leash_enter) begin
                        mode_next        = MODE_LEASH;
                        leash_start_next = time_ms;
                        leash_valid_next = 1'b1;
                        cancel_goals     = cfg.pause_on_leash;
                    end else begin
                        mode_next = MODE_DEGRADED;
                    end
                end else begin
                    leash_count_next = '0;
                    mode_next        = MODE_DEGRADED;
                end
            end
            MODE_LEASH: begin
                if (!link_up) begin
                    mode_next        = MODE_LOST_WAIT;
                    lost_start_next  = time_ms;
                    leash_valid_next = 1'b0;
                    leash_count_next = '0;
                end else if (!trend_falling || (rssi >= cfg.leash_rssi)) begin
                    mode_next        = MODE_MONITOR;
                    leash_count_next = '0;
                    leash_valid_next = 1'b0;
                end else if (leash_valid_reg && leash_expired) begin
                    mode_next        = MODE_LOST_WAIT;
                    lost_start_next  = time_ms;
                    leash_valid_next = 1'b0;
                    leash_count_next = '0;
                end
            end
            MODE_LOST_WAIT: begin
                if (link_up) begin
                    mode_next        = MODE_MONITOR;
                    lost_start_next  = '0;
                    leash_count_next = '0;
                end else if (loss_expired) begin
                    if (cfg.recovery_enable) begin
                        recovery_start = 1'b1;
                        if (nav_nothing_to_do) begin
                            mode_next   = MODE_FAILED;
                            reason_next = lls_pkg::ReasonRecoveryFail;
                        end else begin
                            mode_next   = MODE_RECOVERING;
                            reason_next = lls_pkg::ReasonNone;
                        end
                    end else begin
                        mode_next   = MODE_FAILED;
                        reason_next = lls_pkg::ReasonRecoveryOff;
                    end
                end
            end
            MODE_RECOVERING: begin
                if (link_up) begin
                    cancel_goals       = 1'b1;
                    mode_next          = MODE_SUCCEEDED;
                    success_start_next = time_ms;
                    success_valid_next = 1'b1;
                    reason_next        = lls_pkg::ReasonReacquired;
                end else if (nav_all_done) begin
                    mode_next   = MODE_FAILED;
                    reason_next = lls_pkg::ReasonRecoveryFail;
                end
            end
            MODE_SUCCEEDED: begin
                if (success_valid_reg && hold_expired) begin
                    mode_next          = MODE_MONITOR;
                    success_valid_next = 1'b0;
                    success_start_next = '0;
                    leash_count_next   = '0;
                end
            end
            MODE_FAILED: begin
                if (link_up) begin
                    mode_next        = MODE_MONITOR;
                    leash_count_next = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_MONITOR;
            leash_count_reg   <= '0;
            leash_start_reg   <= '0;
            leash_valid_reg   <= 1'b0;
            lost_start_reg    <= '0;
            success_start_reg <= '0;
            success_valid_reg <= 1'b0;
            reason_reg        <= lls_pkg::ReasonNone;
        end else if (step) begin
            mode_reg          <= mode_next;
            leash_count_reg   <= leash_count_next;
            leash_start_reg   <= leash_start_next;
            leash_valid_reg   <= leash_valid_next;
            lost_start_reg    <= lost_start_next;
            success_start_reg <= success_start_next;
            success_valid_reg <= success_valid_next;
            reason_reg        <= reason_next;
        end
    end

    assign result.mode           = mode_next;
    assign result.recovery_start = recovery_start;
    assign result.cancel_goals   = cancel_goals;
    assign result.reason         = reason_next;
    assign result.mode_changed   = (mode_next != mode_reg);

endmodule

[rtl/lls_checker.sv]
// Port-level checks of the link-loss supervisor, bound to the top level.
// Depends on link_loss_supervisor_defines.svh and lls_pkg.
`include "link_loss_supervisor_defines.svh"

module lls_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_mode,
    input logic       m_recovery_start,
    input logic       m_cancel_goals,
    input logic [1:0] m_reason,
    input logic       m_mode_changed
);

    logic       stalled;
    logic [7:0] out_bits;
    logic       start_ok;
    logic       success_entry;
    logic       success_ok;

    assign stalled       = m_valid && !m_ready;
    assign out_bits      = {m_mode, m_recovery_start, m_cancel_goals, m_reason, m_mode_changed};
    assign start_ok      = m_mode_changed && (m_mode == lls_pkg::ModeRecovering ||
                                              m_mode == lls_pkg::ModeFailed);
    assign success_entry = m_valid && m_mode_changed && (m_mode == lls_pkg::ModeSucceeded);
    assign success_ok    = m_cancel_goals && (m_reason == lls_pkg::ReasonReacquired);

    `LLS_ASSERT_NEXT(a_out_hold, aclk, aresetn, stalled, m_valid && $stable(out_bits), "stall broke hold")
    `LLS_ASSERT_IMPLY(a_start_mode, aclk, aresetn, m_valid && m_recovery_start, start_ok, "bad start")
    `LLS_ASSERT_IMPLY(a_success_entry, aclk, aresetn, success_entry, success_ok, "bad success entry")
    `LLS_ASSERT_IMPLY(a_mode_range, aclk, aresetn, m_valid, m_mode <= lls_pkg::ModeFailed, "bad mode")

endmodule

bind link_loss_supervisor lls_checker u_lls_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_mode           (m_mode),
    .m_recovery_start (m_recovery_start),
    .m_cancel_goals   (m_cancel_goals),
    .m_reason         (m_reason),
    .m_mode_changed   (m_mode_changed)
);
